FILE: design/dart_pkg.sv
// Shared types, codes and constants of the divider and reload timer.
`default_nettype none
package dart_pkg;

  // Default number of ticks per DIV increment.
  localparam int unsigned DIV_PERIOD_DEF = 256;

  // Item kinds.
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;

  // Register selects.
  localparam logic [1:0] REG_DIV  = 2'd0;
  localparam logic [1:0] REG_TIMA = 2'd1;
  localparam logic [1:0] REG_TMA  = 2'd2;
  localparam logic [1:0] REG_TAC  = 2'd3;

  // TAC fields.
  localparam int unsigned TAC_ENABLE_BIT = 2;

  localparam int unsigned ACC_W = 11;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] reg_select;
    logic [7:0] write_data;
    logic       cpu_stopped;
  } in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       timer_irq;
  } out_t;

  // Tick count at which TIMA advances, chosen by TAC bits 1:0.
  function automatic logic [ACC_W-1:0] rate_limit(input logic [1:0] rate_sel);
    logic [ACC_W-1:0] lim;
    case (rate_sel)
      2'd0:    lim = ACC_W'(256 * 4);
      2'd1:    lim = ACC_W'(4 * 4);
      2'd2:    lim = ACC_W'(16 * 4);
      2'd3:    lim = ACC_W'(64 * 4);
      default: lim = ACC_W'(256 * 4);
    endcase
    return lim;
  endfunction

endpackage
`default_nettype wire

FILE: design/divider_and_reload_timer_unit.sv
// Divider and reload timer: input register, timer core and result register.
//
// Each input beat is one master tick, a register read or a register write.
// Every input beat yields exactly one result beat carrying read_data (the
// selected register on a read, zero otherwise) and timer_irq (set on the
// tick at which TIMA reloads from TMA).
// Both channels use valid and stall; a beat moves when valid is high and
// stall is low. The block takes one beat per cycle without gaps while out_stall is low.
// A beat is captured in the input register, the timer core updates its state
// and forms the result on the way to the result register, and the result is
// offered from the result register.
// When the receiver stalls, the result register holds, the input register
// holds behind it and in_stall rises only once both are full.
// Synchronous reset clears DIV, TIMA, TMA, TAC, the prescaler, the rate
// accumulator, the pending reload and both valid flags.
// DIV_PERIOD sets the number of ticks per DIV increment.
`default_nettype none
module divider_and_reload_timer_unit #(
  parameter int unsigned DIV_PERIOD = dart_pkg::DIV_PERIOD_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire dart_pkg::in_t   in_data,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output dart_pkg::out_t       out_data
);
  import dart_pkg::*;

  logic  s1_valid_r, s1_valid_nxt;
  in_t   s1_item_r;
  logic  o_valid_r, o_valid_nxt;
  out_t  o_data_r;
  out_t  core_result;
  logic  o_take, s1_take;

  assign o_take   = !o_valid_r || !out_stall;
  assign s1_take  = s1_valid_r && o_take;
  assign in_stall = s1_valid_r && !o_take;

  assign s1_valid_nxt = (s1_valid_r && !o_take) || in_valid;
  assign o_valid_nxt  = o_take ? s1_valid_r : o_valid_r;

  dart_core #(
    .DIV_PERIOD(DIV_PERIOD)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (s1_take),
    .item   (s1_item_r),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      o_valid_r  <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      o_valid_r  <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_data;
    end
    if (s1_take) begin
      o_data_r <= core_result;
    end
  end

  assign out_valid = o_valid_r;
  assign out_data  = o_data_r;

endmodule
`default_nettype wire

FILE: design/dart_core.sv
// Timer state registers and the single-pass update for one beat.
`default_nettype none
module dart_core #(
  parameter int unsigned DIV_PERIOD = dart_pkg::DIV_PERIOD_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         step,
  input  wire dart_pkg::in_t  item,
  output dart_pkg::out_t    result
);
  import dart_pkg::*;

  localparam int unsigned PW = (DIV_PERIOD > 1) ? $clog2(DIV_PERIOD) : 1;
  localparam logic [PW-1:0] PRE_LAST = PW'(DIV_PERIOD - 1);

  logic [PW-1:0]    pre_r,  pre_nxt;
  logic [7:0]       div_r,  div_nxt;
  logic [7:0]       tima_r, tima_nxt;
  logic [7:0]       tma_r,  tma_nxt;
  logic [7:0]       tac_r,  tac_nxt;
  logic [ACC_W-1:0] acc_r,  acc_nxt;
  logic             pend_r, pend_nxt;

  logic [ACC_W-1:0] acc_inc;
  logic             overflow;

  assign acc_inc = acc_r + ACC_W'(1);

  always_comb begin
    pre_nxt  = pre_r;
    div_nxt  = div_r;
    tima_nxt = tima_r;
    tma_nxt  = tma_r;
    tac_nxt  = tac_r;
    acc_nxt  = acc_r;
    pend_nxt = pend_r;
    overflow = 1'b0;
    result   = '0;
    case (item.kind)
      KIND_TICK: begin
        if (!item.cpu_stopped) begin
          if (pre_r == PRE_LAST) begin
            pre_nxt = '0;
            div_nxt = div_r + 8'd1;
          end else begin
            pre_nxt = pre_r + PW'(1);
          end
          if (tac_r[TAC_ENABLE_BIT]) begin
            if (acc_inc >= rate_limit(tac_r[1:0])) begin
              acc_nxt = '0;
              if (tima_r == 8'hFF) begin
                // TIMA holds 0xFF for this beat; the reload comes on the next tick.
                pend_nxt = 1'b1;
                overflow = 1'b1;
              end else begin
                tima_nxt = tima_r + 8'd1;
              end
            end else begin
              acc_nxt = acc_inc;
            end
          end
        end else begin
          pre_nxt = '0;
          div_nxt = '0;
        end
        if (!overflow && pend_r) begin
          pend_nxt         = 1'b0;
          tima_nxt         = tma_r;
          result.timer_irq = 1'b1;
        end
      end
      KIND_READ: begin
        case (item.reg_select)
          REG_DIV:  result.read_data = div_r;
          REG_TIMA: result.read_data = tima_r;
          REG_TMA:  result.read_data = tma_r;
          default:  result.read_data = tac_r;
        endcase
      end
      KIND_WRITE: begin
        case (item.reg_select)
          REG_DIV:  div_nxt  = item.write_data;
          REG_TIMA: tima_nxt = item.write_data;
          REG_TMA:  tma_nxt  = item.write_data;
          default:  tac_nxt  = item.write_data;
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_r  <= '0;
      div_r  <= '0;
      tima_r <= '0;
      tma_r  <= '0;
      tac_r  <= '0;
      acc_r  <= '0;
      pend_r <= 1'b0;
    end else if (step) begin
      pre_r  <= pre_nxt;
      div_r  <= div_nxt;
      tima_r <= tima_nxt;
      tma_r  <= tma_nxt;
      tac_r  <= tac_nxt;
      acc_r  <= acc_nxt;
      pend_r <= pend_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: verif/tb_divider_and_reload_timer_unit.sv
// Self-checking testbench for the divider and reload timer unit.
`timescale 1ns / 1ps
module tb_divider_and_reload_timer_unit;
  import dart_pkg::*;

  // The kind encoding leaves this value unused; the block must answer it with zeros.
  localparam logic [1:0] KIND_SPARE = 2'd3;
  // TAC rate select for the fastest TIMA step.
  localparam logic [1:0] RATE_FAST = 2'd1;

  localparam int unsigned DIV_TICKS = DIV_PERIOD_DEF;
  localparam int unsigned STEP_TICKS [4] = '{1024, 16, 64, 256};

  localparam int RANDOM_BEATS = 1800;
  localparam int PHASE_BEATS  = 300;
  localparam int QUIET_FROM   = 700;
  localparam int QUIET_TO     = 1200;
  localparam int HOLD_AT      = 1500;
  localparam int HOLD_LEN     = 80;
  localparam int STUCK_LIMIT  = 1000;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  sel;
    logic [7:0]  data;
    logic        stop;
    int unsigned reps;
    logic        typed;
    logic [7:0]  rd;
    logic        irq;
  } dir_row_t;

  typedef struct {
    in_t  beat;
    bit   typed;
    out_t want;
  } stim_rec_t;

  localparam int DIR_ROWS = 30;
  // Rows with typed set carry a result that is plain from the register contents.
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{KIND_READ,  REG_DIV,  8'h00, 1'b0, 1,  1'b1, 8'h00, 1'b0},
    '{KIND_READ,  REG_TIMA, 8'h00, 1'b0, 1,  1'b1, 8'h00, 1'b0},
    '{KIND_READ,  REG_TMA,  8'h00, 1'b0, 1,  1'b1, 8'h00, 1'b0},
    '{KIND_READ,  REG_TAC,  8'h00, 1'b0, 1,  1'b1, 8'h00, 1'b0},
    '{KIND_SPARE, REG_TAC,  8'hFF, 1'b1, 1,  1'b1, 8'h00, 1'b0},
    '{KIND_WRITE, REG_TMA,  8'hFF, 1'b0, 1,  1'b1, 8'h00, 1'b0},
    '{KIND_READ,  REG_TMA,  8'h00, 1'b0, 1,  1'b1, 8'hFF, 1'b0},
    '{KIND_WRITE, REG_DIV,  8'hAB, 1'b0, 1,  1'b1, 8'h00, 1'b0},
    '{KIND_READ,  REG_DIV,  8'h00, 1'b0, 1,  1'b1, 8'hAB, 1'b0},
    '{KIND_TICK,  REG_DIV,  8'h00, 1'b1, 1,  1'b1, 8'h00, 1'b0},
    '{KIND_READ,  REG_DIV,  8'h00, 1'b0, 1,  1'b1, 8'h00, 1'b0},
    '{KIND_WRITE, REG_TIMA, 8'hFF, 1'b0, 1,  1'b1, 8'h00, 1'b0},
    '{KIND_WRITE, REG_TAC,  8'h05, 1'b0, 1,  1'b1, 8'h00, 1'b0},
    '{KIND_TICK,  REG_DIV,  8'h00, 1'b0, 15, 1'b0, 8'h00, 1'b0},
    '{KIND_TICK,  REG_DIV,  8'h00, 1'b0, 1,  1'b1, 8'h00, 1'b0},
    '{KIND_READ,  REG_TIMA, 8'h00, 1'b0, 1,  1'b1, 8'hFF, 1'b0},
    '{KIND_TICK,  REG_DIV,  8'h00, 1'b1, 1,  1'b1, 8'h00, 1'b1},
    '{KIND_READ,  REG_TIMA, 8'h00, 1'b0, 1,  1'b1, 8'hFF, 1'b0},
    '{KIND_WRITE, REG_TAC,  8'h07, 1'b0, 1,  1'b1, 8'h00, 1'b0},
    '{KIND_TICK,  REG_DIV,  8'h00, 1'b0, 18, 1'b0, 8'h00, 1'b0},
    '{KIND_WRITE, REG_TAC,  8'h03, 1'b0, 1,  1'b1, 8'h00, 1'b0},
    '{KIND_TICK,  REG_DIV,  8'h00, 1'b0, 5,  1'b0, 8'h00, 1'b0},
    '{KIND_WRITE, REG_TIMA, 8'h10, 1'b0, 1,  1'b1, 8'h00, 1'b0},
    '{KIND_WRITE, REG_TAC,  8'h05, 1'b0, 1,  1'b1, 8'h00, 1'b0},
    '{KIND_TICK,  REG_DIV,  8'h00, 1'b0, 1,  1'b0, 8'h00, 1'b0},
    '{KIND_READ,  REG_TIMA, 8'h00, 1'b0, 1,  1'b1, 8'h11, 1'b0},
    '{KIND_WRITE, REG_TAC,  8'hFF, 1'b0, 1,  1'b1, 8'h00, 1'b0},
    '{KIND_READ,  REG_TAC,  8'h00, 1'b0, 1,  1'b1, 8'hFF, 1'b0},
    '{KIND_WRITE, REG_TMA,  8'h00, 1'b0, 1,  1'b1, 8'h00, 1'b0},
    '{KIND_READ,  REG_DIV,  8'h00, 1'b0, 1,  1'b0, 8'h00, 1'b0}
  };

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  // Predictor state, mirroring the timer registers.
  int unsigned                prescale_q;
  logic [7:0]                 div_q;
  logic [7:0]                 tima_q;
  logic [7:0]                 tma_q;
  logic [7:0]                 tac_q;
  logic [ACC_W-1:0]           acc_q;
  logic                       reload_q;

  stim_rec_t stim_q [$];
  out_t      pending_results [$];
  int        fault_count;
  int        cyc;
  int        stuck_cycles;

  divider_and_reload_timer_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic out_t predict_timer_result(input in_t beat);
    out_t res;
    logic overflow_now;
    res = '0;
    overflow_now = 1'b0;
    case (beat.kind)
      KIND_TICK: begin
        if (!beat.cpu_stopped) begin
          prescale_q++;
          if (prescale_q >= DIV_TICKS) begin
            prescale_q = 0;
            div_q++;
          end
          if (tac_q[TAC_ENABLE_BIT]) begin
            acc_q++;
            if (acc_q >= STEP_TICKS[tac_q[1:0]]) begin
              acc_q = '0;
              // TIMA holds 0xFF through the overflow tick; the reload waits a tick.
              if (tima_q == 8'hFF) begin
                reload_q = 1'b1;
                overflow_now = 1'b1;
              end else begin
                tima_q++;
              end
            end
          end
        end else begin
          div_q = '0;
          prescale_q = 0;
        end
        if (reload_q && !overflow_now) begin
          reload_q = 1'b0;
          tima_q = tma_q;
          res.timer_irq = 1'b1;
        end
      end
      KIND_READ: begin
        case (beat.reg_select)
          REG_DIV:  res.read_data = div_q;
          REG_TIMA: res.read_data = tima_q;
          REG_TMA:  res.read_data = tma_q;
          default:  res.read_data = tac_q;
        endcase
      end
      KIND_WRITE: begin
        case (beat.reg_select)
          REG_DIV:  div_q = beat.write_data;
          REG_TIMA: tima_q = beat.write_data;
          REG_TMA:  tma_q = beat.write_data;
          default:  tac_q = beat.write_data;
        endcase
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic bit take_gap();
    if (cyc >= QUIET_FROM && cyc < QUIET_TO) return 1'b0;
    return $urandom_range(0, 99) < 11;
  endfunction

  task automatic report_fault(input string msg);
    fault_count++;
    if (fault_count <= REPORT_MAX) $display("%0t: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    if (rst_n) cyc++;
  end

  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  always @(posedge clk) begin : check_results
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_fault($sformatf("result read_data %02h timer_irq %0b with none expected",
                               out_data.read_data, out_data.timer_irq));
      end else begin
        want = pending_results.pop_front();
        if (out_data.read_data !== want.read_data)
          report_fault($sformatf("read_data expected %02h got %02h",
                                 want.read_data, out_data.read_data));
        if (out_data.timer_irq !== want.timer_irq)
          report_fault($sformatf("timer_irq expected %0b got %0b",
                                 want.timer_irq, out_data.timer_irq));
      end
    end
  end

  // Receiver: random stalls, a quiet window, and one long hold so the block backs up.
  initial begin : drain_results
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (cyc == HOLD_AT) begin
        out_stall <= 1'b1;
        repeat (HOLD_LEN) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= take_gap();
      end
    end
  end

  initial begin : run
    stim_rec_t rec;
    bit        offered;
    bit        stop_phase;
    int        pick;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    fault_count = 0;
    cyc = 0;
    stuck_cycles = 0;
    prescale_q = 0;
    div_q = '0;
    tima_q = '0;
    tma_q = '0;
    tac_q = '0;
    acc_q = '0;
    reload_q = 1'b0;

    foreach (DIRECTED[r]) begin
      rec.beat.kind = DIRECTED[r].kind;
      rec.beat.reg_select = DIRECTED[r].sel;
      rec.beat.write_data = DIRECTED[r].data;
      rec.beat.cpu_stopped = DIRECTED[r].stop;
      rec.typed = DIRECTED[r].typed;
      rec.want = {DIRECTED[r].rd, DIRECTED[r].irq};
      repeat (DIRECTED[r].reps) stim_q.push_back(rec);
    end

    // Mostly ticks with the timer enabled and TIMA parked near overflow, so
    // reloads happen often; alternate phases stop the CPU frequently.
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      stop_phase = ((i / PHASE_BEATS) % 2) == 1;
      rec.typed = 1'b0;
      rec.want = '0;
      rec.beat.reg_select = 2'($urandom);
      rec.beat.write_data = 8'($urandom);
      rec.beat.cpu_stopped = stop_phase ? ($urandom_range(0, 3) == 0)
                                        : ($urandom_range(0, 399) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 76) begin
        rec.beat.kind = KIND_TICK;
      end else if (pick < 87) begin
        rec.beat.kind = KIND_READ;
      end else if (pick < 98) begin
        rec.beat.kind = KIND_WRITE;
        if (rec.beat.reg_select == REG_TAC && $urandom_range(0, 5) != 0) begin
          rec.beat.write_data[TAC_ENABLE_BIT] = 1'b1;
          if ($urandom_range(0, 1)) rec.beat.write_data[1:0] = RATE_FAST;
        end else if (rec.beat.reg_select == REG_TIMA && $urandom_range(0, 1)) begin
          rec.beat.write_data = 8'hFF - 8'($urandom_range(0, 2));
        end
      end else begin
        rec.beat.kind = KIND_SPARE;
      end
      stim_q.push_back(rec);
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    offered = 1'b0;
    while (stim_q.size() != 0) begin
      @(negedge clk);
      if (!offered) begin
        if (take_gap()) begin
          in_valid <= 1'b0;
        end else begin
          in_data <= stim_q[0].beat;
          in_valid <= 1'b1;
          offered = 1'b1;
        end
      end
      @(posedge clk);
      if (offered && !in_stall) begin
        rec = stim_q.pop_front();
        if (rec.typed) begin
          void'(predict_timer_result(rec.beat));
          pending_results.push_back(rec.want);
        end else begin
          pending_results.push_back(predict_timer_result(rec.beat));
        end
        offered = 1'b0;
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fault_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
